FILE: rtl/rcdc_pkg.sv
package rcdc_pkg;

  localparam int unsigned DefWindowBytes = 32;
  localparam logic [31:0] Polynomial = 32'h4D96_4885;

  localparam int unsigned CountW = 16;
  localparam int unsigned PrintW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] MinSegmentRst = 16'd2048;
  localparam logic [15:0] MaxSegmentRst = 16'hFFFF;
  localparam logic [31:0] BoundaryMaskRst = 32'h0000_0FFF;
  localparam logic [31:0] BoundaryValueRst = 32'h0000_0000;

  typedef enum logic [1:0] {
    CUT_NONE  = 2'd0,
    CUT_MATCH = 2'd1,
    CUT_MAX   = 2'd2,
    CUT_LAST  = 2'd3
  } cut_reason_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_SEGMENT    = 2'd0,
    REG_MAX_SEGMENT    = 2'd1,
    REG_BOUNDARY_MASK  = 2'd2,
    REG_BOUNDARY_VALUE = 2'd3
  } cfg_reg_e;

  typedef logic [255:0][PrintW-1:0] tab_t;

  // x * t^32 mod P
  function automatic logic [PrintW-1:0] mul_t32(logic [PrintW-1:0] x);
    logic [PrintW-1:0] v;
    v = x;
    for (int k = 0; k < 32; k++) begin
      if (v[31]) begin
        v = (v << 1) ^ Polynomial;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

  // x * t^(8*(window_bytes-1)) mod P
  function automatic logic [PrintW-1:0] mul_window(logic [7:0] x, int unsigned window_bytes);
    int unsigned power;
    int unsigned rest;
    int unsigned rounds;
    logic [PrintW-1:0] v;
    power = 8 * (window_bytes - 1);
    rest = power & 31;
    rounds = power >> 5;
    v = {24'd0, x} << rest;
    for (int unsigned n = 0; n < rounds; n++) begin
      v = mul_t32(v);
    end
    return v;
  endfunction

  function automatic tab_t build_shift_tab();
    tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = mul_t32(32'(i));
    end
    return t;
  endfunction

  function automatic tab_t build_win_tab(int unsigned window_bytes);
    tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = mul_window(8'(i), window_bytes);
    end
    return t;
  endfunction

endpackage

FILE: rtl/rabin_content_defined_chunker.sv
// Results are registered: each accepted byte updates the result register.
// Throughput: one byte per cycle unless the result register stalls; the
// fingerprint update is a combinational shift-table lookup and XOR loop, fed
// by a window-table value prefetched from a chain of WINDOW_BYTES-1 byte cells.
// Reset: asynchronous, clears print, count, output valid and restores the
// configuration registers; the byte cells are not reset.
module rabin_content_defined_chunker #(
  parameter int unsigned WindowBytes = rcdc_pkg::DefWindowBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcdc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcdc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          boundary_o,
  output logic [15:0]                   chunk_length_o,
  output logic [31:0]                   fingerprint_o,
  output logic [1:0]                    cut_reason_o
);
  import rcdc_pkg::*;

  localparam int unsigned NumCells = WindowBytes - 1;
  localparam tab_t ShiftTab = build_shift_tab();
  localparam tab_t WinTab = build_win_tab(WindowBytes);
  localparam logic [CountW-1:0] WinCount = CountW'(WindowBytes);

  logic [15:0] min_segment_q, max_segment_q;
  logic [31:0] boundary_mask_q, boundary_value_q;

  logic [PrintW-1:0] print_q, print_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PrintW-1:0] win_val_q;

  logic              out_valid_q;
  logic              boundary_q;
  logic [CountW-1:0] length_q;
  logic [PrintW-1:0] fprint_q;
  cut_reason_e       reason_q, reason_d;

  logic              accept;
  logic [PrintW-1:0] h_pre, h_new;
  logic [CountW-1:0] count_inc;
  logic [7:0]        chain [NumCells+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_segment_q    <= MinSegmentRst;
      max_segment_q    <= MaxSegmentRst;
      boundary_mask_q  <= BoundaryMaskRst;
      boundary_value_q <= BoundaryValueRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MIN_SEGMENT:    min_segment_q    <= cfg_data_i[15:0];
        REG_MAX_SEGMENT:    max_segment_q    <= cfg_data_i[15:0];
        REG_BOUNDARY_MASK:  boundary_mask_q  <= cfg_data_i;
        REG_BOUNDARY_VALUE: boundary_value_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance whenever the result register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  // byte shift line: chain[k+1] holds the byte k+1 transactions old
  assign chain[0] = data_byte_i;
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    rcdc_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (accept),
      .byte_i (chain[g]),
      .byte_o (chain[g+1])
    );
  end

  // prefetch the removal term for the byte that leaves on the next transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_val_q <= WinTab[chain[NumCells]];
    end
  end

  always_comb begin
    h_pre = (count_q >= WinCount) ? (print_q ^ win_val_q) : print_q;
    h_new = {h_pre[23:0], data_byte_i} ^ ShiftTab[h_pre[31:24]];
    count_inc = (count_q == '1) ? count_q : count_q + CountW'(1);

    reason_d = CUT_NONE;
    if (count_inc > WinCount) begin
      if (count_inc >= max_segment_q) begin
        reason_d = CUT_MAX;
      end else if (count_inc >= min_segment_q &&
                   (h_new & boundary_mask_q) == boundary_value_q) begin
        reason_d = CUT_MATCH;
      end
    end
    if (reason_d == CUT_NONE && last_byte_i) begin
      reason_d = CUT_LAST;
    end

    if (reason_d != CUT_NONE) begin
      print_d = '0;
      count_d = '0;
    end else begin
      print_d = h_new;
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      print_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        print_q     <= print_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      boundary_q <= (reason_d != CUT_NONE);
      length_q   <= count_inc;
      fprint_q   <= h_new;
      reason_q   <= reason_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign boundary_o     = boundary_q;
  assign chunk_length_o = length_q;
  assign fingerprint_o  = fprint_q;
  assign cut_reason_o   = reason_q;

endmodule

FILE: rtl/rcdc_cell.sv
module rcdc_cell (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);
  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/rcdc_checker.sv
module rcdc_checker #(
  parameter int unsigned WindowBytes = rcdc_pkg::DefWindowBytes
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          boundary_o,
  input logic [15:0]                   chunk_length_o,
  input logic [31:0]                   fingerprint_o,
  input logic [1:0]                    cut_reason_o
);
  import rcdc_pkg::*;

  a_boundary_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (boundary_o == (cut_reason_o != CUT_NONE)))
    else $error("boundary flag disagrees with cut reason");

  a_first_byte_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_length_o == 16'd1 |-> fingerprint_o[31:8] == 24'd0)
    else $error("first byte of a chunk carries stale fingerprint bits");

  a_tested_cut_past_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cut_reason_o == CUT_MATCH || cut_reason_o == CUT_MAX)
    |-> chunk_length_o > 16'(WindowBytes))
    else $error("length or pattern cut inside the first window");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result register can advance");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fingerprint_o) &&
    $stable(chunk_length_o) && $stable(cut_reason_o))
    else $error("stalled result transaction changed");

endmodule

bind rabin_content_defined_chunker rcdc_checker #(.WindowBytes(WindowBytes)) u_rcdc_checker (.*);
